@@ rtl/one_wire_rom_search_assert.svh @@
// Assertion macros included by one_wire_rom_search.sv.
`ifndef ONE_WIRE_ROM_SEARCH_ASSERT_SVH
`define ONE_WIRE_ROM_SEARCH_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define OWRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("one_wire_rom_search: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define OWRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("one_wire_rom_search: assertion failed");

`endif

@@ rtl/owrs_pkg.sv @@
package owrs_pkg;

    localparam int unsigned ROM_BITS = 64;
    localparam int unsigned POS_W = 7;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned FAM_W = 4;

    localparam logic [POS_W-1:0] LAST_POS = 7'd64;
    localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;
    localparam logic [POS_W-1:0] FIRST_POS = 7'd1;

    typedef enum logic [1:0] {
        MODE_FIRST = 2'd0,
        MODE_NEXT  = 2'd1,
        MODE_BITS  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [ROM_BITS-1:0] rom_store;
        logic [POS_W-1:0]    last_conflict;
        logic [FAM_W-1:0]    last_family_conflict;
        logic                last_device_seen;
        logic [POS_W-1:0]    bit_position;
        logic [POS_W-1:0]    pass_last_zero;
        logic                searching;
    } search_state_t;

    typedef struct packed {
        logic                send_command;
        logic                bit_valid;
        logic                send_bit;
        logic                done_res;
        logic                found;
        logic [ROM_BITS-1:0] rom_code;
        logic [FAM_W-1:0]    family_discrepancy;
    } search_result_t;

endpackage

@@ rtl/owrs_step.sv @@
module owrs_step (
    input  owrs_pkg::search_state_t  state_cur,
    input  logic [1:0]               mode,
    input  logic                     presence,
    input  logic                     id_bit,
    input  logic                     comp_bit,
    output owrs_pkg::search_state_t  state_nxt,
    output owrs_pkg::search_result_t result
);

    logic [owrs_pkg::POS_W-1:0] pos;
    logic [owrs_pkg::IDX_W-1:0] idx;
    logic                       dir;

    assign pos = state_cur.bit_position;
    assign idx = pos[owrs_pkg::IDX_W-1:0] - {{(owrs_pkg::IDX_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        state_nxt = state_cur;
        result = '0;
        dir = 1'b0;
        case (mode)
            owrs_pkg::MODE_FIRST, owrs_pkg::MODE_NEXT:
            begin
                if (mode == owrs_pkg::MODE_FIRST)
                begin
                    state_nxt.last_conflict = '0;
                    state_nxt.last_device_seen = 1'b0;
                    state_nxt.last_family_conflict = '0;
                end
                if (state_nxt.last_device_seen || !presence)
                begin
                    state_nxt.last_conflict = '0;
                    state_nxt.last_device_seen = 1'b0;
                    state_nxt.last_family_conflict = '0;
                    state_nxt.searching = 1'b0;
                    result.done_res = 1'b1;
                end
                else
                begin
                    state_nxt.searching = 1'b1;
                    state_nxt.bit_position = owrs_pkg::FIRST_POS;
                    state_nxt.pass_last_zero = '0;
                    result.send_command = 1'b1;
                end
            end
            owrs_pkg::MODE_BITS:
            begin
                if (state_cur.searching)
                begin
                    if (id_bit && comp_bit)
                    begin
                        state_nxt.last_conflict = '0;
                        state_nxt.last_device_seen = 1'b0;
                        state_nxt.last_family_conflict = '0;
                        state_nxt.searching = 1'b0;
                        result.done_res = 1'b1;
                    end
                    else
                    begin
                        if (id_bit != comp_bit)
                        begin
                            dir = id_bit;
                        end
                        else
                        begin
                            if (pos < state_cur.last_conflict)
                            begin
                                dir = state_cur.rom_store[idx];
                            end
                            else
                            begin
                                dir = (pos == state_cur.last_conflict);
                            end
                            if (!dir)
                            begin
                                state_nxt.pass_last_zero = pos;
                                if (pos < owrs_pkg::FAMILY_LIMIT)
                                begin
                                    state_nxt.last_family_conflict = pos[owrs_pkg::FAM_W-1:0];
                                end
                            end
                        end
                        state_nxt.rom_store[idx] = dir;
                        result.bit_valid = 1'b1;
                        result.send_bit = dir;
                        if (pos >= owrs_pkg::LAST_POS)
                        begin
                            state_nxt.searching = 1'b0;
                            result.done_res = 1'b1;
                            state_nxt.last_conflict = state_nxt.pass_last_zero;
                            if (state_nxt.pass_last_zero == '0)
                            begin
                                state_nxt.last_device_seen = 1'b1;
                            end
                            if (state_nxt.rom_store[7:0] == 8'h00)
                            begin
                                state_nxt.last_conflict = '0;
                                state_nxt.last_device_seen = 1'b0;
                                state_nxt.last_family_conflict = '0;
                            end
                            else
                            begin
                                result.found = 1'b1;
                                result.rom_code = state_nxt.rom_store;
                            end
                        end
                        else
                        begin
                            state_nxt.bit_position = pos + owrs_pkg::FIRST_POS;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        result.family_discrepancy = state_nxt.last_family_conflict;
    end

endmodule

@@ rtl/one_wire_rom_search.sv @@
// An accepted transaction waits in the input registers, then moves to the result registers
// when the output is empty or taken. Throughput: one transaction per cycle while out_ready
// is high; each bit decision is one pass of short logic on the registered search state.
// Reset: rst_n is asynchronous and active low; it clears the search state
// (ROM code, conflict positions, last-device flag) and leaves the engine idle.
module one_wire_rom_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic        presence,
    input  logic        id_bit,
    input  logic        comp_bit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        send_command,
    output logic        bit_valid,
    output logic        send_bit,
    output logic        done_res,
    output logic        found,
    output logic [63:0] rom_code,
    output logic [3:0]  family_discrepancy
);

`include "one_wire_rom_search_assert.svh"

    logic                     in_valid_reg;
    logic                     in_valid_next;
    logic [1:0]               mode_reg;
    logic                     presence_reg;
    logic                     id_bit_reg;
    logic                     comp_bit_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     advance;
    owrs_pkg::search_state_t  state_reg;
    owrs_pkg::search_state_t  state_next;
    owrs_pkg::search_result_t result_reg;
    owrs_pkg::search_result_t result_next;

    assign advance = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    owrs_step u_step (
        .state_cur  (state_reg),
        .mode       (mode_reg),
        .presence   (presence_reg),
        .id_bit     (id_bit_reg),
        .comp_bit   (comp_bit_reg),
        .state_nxt  (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            presence_reg <= presence;
            id_bit_reg <= id_bit;
            comp_bit_reg <= comp_bit;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign send_command = result_reg.send_command;
    assign bit_valid = result_reg.bit_valid;
    assign send_bit = result_reg.send_bit;
    assign done_res = result_reg.done_res;
    assign found = result_reg.found;
    assign rom_code = result_reg.rom_code;
    assign family_discrepancy = result_reg.family_discrepancy;

    `OWRS_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, out_valid_reg)
    `OWRS_ASSERT_NOW(a_found_needs_done, clk, rst_n, out_valid_reg && found, done_res)
    `OWRS_ASSERT_NOW(a_cmd_or_bit, clk, rst_n, out_valid_reg, !(send_command && bit_valid))
    `OWRS_ASSERT_NOW(a_search_pos_range, clk, rst_n, state_reg.searching,
        (state_reg.bit_position != '0) && (state_reg.bit_position <= owrs_pkg::LAST_POS))
    `OWRS_ASSERT_NOW(a_bit_needs_valid, clk, rst_n, out_valid_reg && send_bit, bit_valid)

endmodule
